// ----- src/ray_segment_intersect_assert.svh -----
// Assertion helpers used by the checker file rsi_checker.sv.
`ifndef RAY_SEGMENT_INTERSECT_ASSERT_SVH
`define RAY_SEGMENT_INTERSECT_ASSERT_SVH

// Checked only while out of reset.
`define RSI_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ray_segment_intersect assertion failed");

// Checked at every edge, reset included.
`define RSI_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ray_segment_intersect assertion failed");

`endif

// ----- src/rsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared constants, types and helpers of the ray/segment intersection block.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int QUEUE_DEPTH      = 4;

  // CORDIC gain 0.6072529350 in Q2.30
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

  localparam logic [31:0] ATAN_TABLE [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Register index carried in paddr[2]
  localparam logic REG_NEAR_ZERO = 1'b0;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_CROSS = 2'd1,
    KIND_COLIN = 2'd2
  } kind_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Width of a direction component in Q.FRAC_BITS
  function automatic int dir_w(input int fb);
    return fb + 2;
  endfunction

  // Width of a cross product of a direction and a 33-bit offset
  function automatic int cross_w(input int fb);
    return fb + 36;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- src/rsi_in_if.sv -----
// ----------------------------------------------------------------------------
// rsi_in_if
// Input channel: one ray/segment test per item.
// ----------------------------------------------------------------------------
interface rsi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] seg_start_x;
  logic signed [31:0] seg_start_y;
  logic signed [31:0] seg_end_x;
  logic signed [31:0] seg_end_y;
  logic signed [31:0] ray_start_x;
  logic signed [31:0] ray_start_y;
  logic        [15:0] ray_angle;

  modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  ray_start_x, ray_start_y, ray_angle, input ready);
  modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                ray_start_x, ray_start_y, ray_angle, output ready);
endinterface

// ----- src/rsi_out_if.sv -----
// ----------------------------------------------------------------------------
// rsi_out_if
// Output channel: one hit result per item.
// ----------------------------------------------------------------------------
interface rsi_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  hit_kind;
  logic signed [31:0] hit_x;
  logic signed [31:0] hit_y;

  modport source (output valid, hit_kind, hit_x, hit_y, input ready);
  modport sink (input valid, hit_kind, hit_x, hit_y, output ready);
endinterface

// ----- src/rsi_cordic.sv -----
// ----------------------------------------------------------------------------
// rsi_cordic
// Pipelined rotation CORDIC: binary angle to unit direction in Q.FRAC_BITS.
// ----------------------------------------------------------------------------
module rsi_cordic
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [15:0]                        angle_i,
  output logic signed [dir_w(FRAC_BITS)-1:0] rx_o,
  output logic signed [dir_w(FRAC_BITS)-1:0] ry_o
);

  localparam int RW = dir_w(FRAC_BITS);
  localparam int XW = 34;
  localparam int N  = CORDIC_STEPS;
  localparam logic signed [XW-1:0] HALF = XW'(64'd1 << (29 - FRAC_BITS));

  logic signed [XW-1:0] x_q [N+1];
  logic signed [XW-1:0] y_q [N+1];
  logic signed [XW-1:0] z_q [N+1];
  logic                 flip_q [N+1];

  logic [31:0] a_full;
  logic        flip_in;
  logic [31:0] a_fold;

  // fold the left half plane onto the right one
  assign a_full  = {angle_i, 16'h0000};
  assign flip_in = a_full[31] ^ a_full[30];
  assign a_fold  = flip_in ? (a_full ^ 32'h80000000) : a_full;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= XW'(CORDIC_GAIN);
      y_q[0]    <= '0;
      z_q[0]    <= XW'($signed(a_fold));
      flip_q[0] <= flip_in;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [XW-1:0] atan_s;
    assign atan_s = $signed({2'b00, ATAN_TABLE[i]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][XW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_s;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_s;
        end
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  logic signed [XW-1:0] xr, yr;
  logic signed [RW-1:0] xs, ys;

  always_comb begin
    xr = (x_q[N] + HALF) >>> (30 - FRAC_BITS);
    yr = (y_q[N] + HALF) >>> (30 - FRAC_BITS);
    xs = xr[RW-1:0];
    ys = yr[RW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_o <= flip_q[N] ? -xs : xs;
      ry_o <= flip_q[N] ? -ys : ys;
    end
  end

endmodule

// ----- src/rsi_front.sv -----
// ----------------------------------------------------------------------------
// rsi_front
// Accepts items, forms direction and cross products, classifies each test.
// ----------------------------------------------------------------------------
module rsi_front
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter type entry_t     = logic
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsi_in_if.sink      in_ch,
  input  logic [15:0] near_zero_i,
  input  q_stat_t     q_stat_i,
  output logic        push_o,
  output entry_t      entry_o
);

  localparam int RW  = dir_w(FRAC_BITS);
  localparam int PW  = RW + 33;
  localparam int CW  = cross_w(FRAC_BITS);
  localparam int DW  = CW - FRAC_BITS;
  localparam int MW  = RW + DW;
  localparam int TW  = 67;
  localparam int L   = CORDIC_STEPS + 1;
  localparam logic [31:0] MISS = ~((32'd1 << FRAC_BITS) - 32'd1);

  typedef struct packed {
    logic signed [31:0] qx, qy, px, py;
    logic signed [32:0] sx, sy, wx, wy, vx, vy;
  } side_t;

  logic  en;
  side_t side_q [L+1];
  logic  vside_q [L+1];
  side_t side_in;
  logic signed [RW-1:0] rx, ry;
  entry_t f_q;

  logic vp_q, vc_q, vk_q, vm_q, vf_q;

  assign en          = !(vf_q && q_stat_i.full);
  assign in_ch.ready = en;
  assign push_o      = vf_q && !q_stat_i.full;
  assign entry_o     = f_q;

  always_comb begin
    side_in.qx = in_ch.seg_start_x;
    side_in.qy = in_ch.seg_start_y;
    side_in.px = in_ch.ray_start_x;
    side_in.py = in_ch.ray_start_y;
    side_in.sx = 33'(in_ch.seg_end_x) - 33'(in_ch.seg_start_x);
    side_in.sy = 33'(in_ch.seg_end_y) - 33'(in_ch.seg_start_y);
    side_in.wx = 33'(in_ch.seg_start_x) - 33'(in_ch.ray_start_x);
    side_in.wy = 33'(in_ch.seg_start_y) - 33'(in_ch.ray_start_y);
    side_in.vx = 33'(in_ch.seg_end_x) - 33'(in_ch.ray_start_x);
    side_in.vy = 33'(in_ch.seg_end_y) - 33'(in_ch.ray_start_y);
  end

  rsi_cordic #(
    .FRAC_BITS   (FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .en_i   (en),
    .angle_i(in_ch.ray_angle),
    .rx_o   (rx),
    .ry_o   (ry)
  );

  // side data travels alongside the CORDIC stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int k = 1; k <= L; k++) side_q[k] <= side_q[k-1];
    end
  end

  // products
  logic signed [PW-1:0] p_a1, p_a2, p_b1, p_b2, p_c1, p_c2, p_e1, p_e2;
  logic signed [65:0]   p_t1, p_t2;
  logic signed [RW-1:0] p_rx, p_ry;
  side_t                p_sd;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_a1 <= rx * side_q[L].sy;
      p_a2 <= ry * side_q[L].sx;
      p_b1 <= side_q[L].wx * ry;
      p_b2 <= side_q[L].wy * rx;
      p_c1 <= side_q[L].wx * rx;
      p_c2 <= side_q[L].wy * ry;
      p_e1 <= side_q[L].vx * rx;
      p_e2 <= side_q[L].vy * ry;
      p_t1 <= side_q[L].wx * side_q[L].sy;
      p_t2 <= side_q[L].wy * side_q[L].sx;
      p_rx <= rx;
      p_ry <= ry;
      p_sd <= side_q[L];
    end
  end

  // cross products and endpoint distances
  logic signed [CW-1:0] c_rxs, c_wxr;
  logic signed [DW-1:0] c_d1, c_d2;
  logic                 c_ts_neg, c_ts_zero;
  logic signed [RW-1:0] c_rx, c_ry;
  side_t                c_sd;
  logic signed [CW-1:0] dot1, dot2;
  logic signed [TW-1:0] tsd;

  always_comb begin
    dot1 = CW'(p_c1) + CW'(p_c2);
    dot2 = CW'(p_e1) + CW'(p_e2);
    tsd  = TW'(p_t1) - TW'(p_t2);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_rxs     <= CW'(p_a1) - CW'(p_a2);
      c_wxr     <= CW'(p_b1) - CW'(p_b2);
      c_d1      <= $signed(dot1[CW-1:FRAC_BITS]);
      c_d2      <= $signed(dot2[CW-1:FRAC_BITS]);
      c_ts_neg  <= tsd[TW-1];
      c_ts_zero <= (tsd == '0);
      c_rx      <= p_rx;
      c_ry      <= p_ry;
      c_sd      <= p_sd;
    end
  end

  // classify
  logic signed [CW-1:0] tol_s;
  logic                 near_rxs, near_wxr, ts_fail;
  logic signed [DW-1:0] dsel;
  kind_e                kind_c;

  always_comb begin
    tol_s    = $signed(CW'({near_zero_i, {FRAC_BITS{1'b0}}}));
    near_rxs = (c_rxs <= tol_s) && (c_rxs >= -tol_s);
    near_wxr = (c_wxr <= tol_s) && (c_wxr >= -tol_s);
    ts_fail  = !c_ts_zero && (c_ts_neg != c_rxs[CW-1]);
    if (c_d1[DW-1]) dsel = c_d2;
    else if (c_d2[DW-1]) dsel = c_d1;
    else dsel = (c_d1 < c_d2) ? c_d1 : c_d2;
    if (near_rxs) begin
      kind_c = (near_wxr && !(c_d1[DW-1] && c_d2[DW-1])) ? KIND_COLIN : KIND_NONE;
    end else begin
      kind_c = ts_fail ? KIND_NONE : KIND_CROSS;
    end
  end

  kind_e                k_kind;
  logic signed [CW-1:0] k_n, k_d;
  logic signed [DW-1:0] k_dsel;
  logic signed [RW-1:0] k_rx, k_ry;
  side_t                k_sd;

  always_ff @(posedge clk_i) begin
    if (en) begin
      k_kind <= kind_c;
      k_n    <= c_rxs[CW-1] ? -c_wxr : c_wxr;
      k_d    <= c_rxs[CW-1] ? -c_rxs : c_rxs;
      k_dsel <= dsel;
      k_rx   <= c_rx;
      k_ry   <= c_ry;
      k_sd   <= c_sd;
    end
  end

  // range check of u, colinear point products
  kind_e                m_kind;
  logic [CW-1:0]        m_n, m_d;
  logic signed [MW-1:0] m_mx, m_my;
  side_t                m_sd;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_kind <= (k_kind == KIND_CROSS && (k_n[CW-1] || k_n > k_d)) ? KIND_NONE : k_kind;
      m_n    <= $unsigned(k_n);
      m_d    <= $unsigned(k_d);
      m_mx   <= k_rx * k_dsel;
      m_my   <= k_ry * k_dsel;
      m_sd   <= k_sd;
    end
  end

  logic signed [63:0]  sum_x, sum_y;
  logic signed [31:0]  col_x, col_y;

  always_comb begin
    sum_x = 64'(m_sd.px) + 64'(m_mx >>> FRAC_BITS);
    sum_y = 64'(m_sd.py) + 64'(m_my >>> FRAC_BITS);
    col_x = sat32(sum_x);
    col_y = sat32(sum_y);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q.kind <= m_kind;
      f_q.sx   <= m_sd.sx;
      f_q.sy   <= m_sd.sy;
      f_q.n    <= m_n;
      f_q.d    <= m_d;
      case (m_kind)
        KIND_COLIN: begin
          f_q.x0 <= col_x;
          f_q.y0 <= col_y;
        end
        KIND_CROSS: begin
          f_q.x0 <= m_sd.qx;
          f_q.y0 <= m_sd.qy;
        end
        default: begin
          f_q.x0 <= $signed(MISS);
          f_q.y0 <= $signed(MISS);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= L; k++) vside_q[k] <= 1'b0;
      vp_q <= 1'b0;
      vc_q <= 1'b0;
      vk_q <= 1'b0;
      vm_q <= 1'b0;
      vf_q <= 1'b0;
    end else if (en) begin
      vside_q[0] <= in_ch.valid;
      for (int k = 1; k <= L; k++) vside_q[k] <= vside_q[k-1];
      vp_q <= vside_q[L];
      vc_q <= vp_q;
      vk_q <= vc_q;
      vm_q <= vk_q;
      vf_q <= vm_q;
    end
  end

endmodule

// ----- src/rsi_queue.sv -----
// ----------------------------------------------------------------------------
// rsi_queue
// Short FIFO between the classifying front and the dividing back.
// ----------------------------------------------------------------------------
module rsi_queue
  import rsi_pkg::*;
#(
  parameter int  DEPTH   = QUEUE_DEPTH,
  parameter type entry_t = logic
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  entry_t  data_i,
  input  logic    pop_i,
  output entry_t  data_o,
  output q_stat_t stat_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign data_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- src/rsi_back.sv -----
// ----------------------------------------------------------------------------
// rsi_back
// Divides out u one bit per stage, scales the segment and drives results.
// ----------------------------------------------------------------------------
module rsi_back
  import rsi_pkg::*;
#(
  parameter int  FRAC_BITS = FRAC_BITS_DEF,
  parameter type entry_t   = logic
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_stat_t q_stat_i,
  input  entry_t  entry_i,
  output logic    pop_o,
  rsi_out_if.source out_ch
);

  localparam int NW = cross_w(FRAC_BITS);
  localparam int S  = FRAC_BITS + 1;
  localparam int MW = 33 + FRAC_BITS + 2;

  logic en;
  logic o_v_q;

  entry_t           e_q  [S+1];
  logic             v_q  [S+1];
  logic [NW:0]      un_q [S+1];
  logic [FRAC_BITS:0] uf_q [S+1];

  assign en    = !(o_v_q && !out_ch.ready);
  assign pop_o = en && !q_stat_i.empty;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q[0]  <= entry_i;
      un_q[0] <= {1'b0, entry_i.n};
      uf_q[0] <= '0;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 1; j <= S; j++) begin : g_div
    logic [NW:0] trial;
    logic [NW:0] dd;
    logic        ge;
    always_comb begin
      dd    = {1'b0, e_q[j-1].d};
      trial = (j == 1) ? un_q[j-1] : {un_q[j-1][NW-1:0], 1'b0};
      ge    = (trial >= dd);
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        e_q[j]  <= e_q[j-1];
        un_q[j] <= ge ? trial - dd : trial;
        uf_q[j] <= {uf_q[j-1][FRAC_BITS-1:0], ge};
      end
    end
  end

  kind_e                m_kind;
  logic signed [31:0]   m_x0, m_y0;
  logic signed [MW-1:0] m_mx, m_my;
  logic                 m_v_q;
  logic signed [FRAC_BITS+1:0] ufs;

  assign ufs = $signed({1'b0, uf_q[S]});

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_kind <= e_q[S].kind;
      m_x0   <= e_q[S].x0;
      m_y0   <= e_q[S].y0;
      m_mx   <= e_q[S].sx * ufs;
      m_my   <= e_q[S].sy * ufs;
    end
  end

  logic signed [63:0] sum_x, sum_y;
  logic        [1:0]  o_kind_q;
  logic signed [31:0] o_x_q, o_y_q;

  always_comb begin
    sum_x = 64'(m_x0) + 64'(m_mx >>> FRAC_BITS);
    sum_y = 64'(m_y0) + 64'(m_my >>> FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_kind_q <= m_kind;
      if (m_kind == KIND_CROSS) begin
        o_x_q <= sat32(sum_x);
        o_y_q <= sat32(sum_y);
      end else begin
        o_x_q <= m_x0;
        o_y_q <= m_y0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= S; k++) v_q[k] <= 1'b0;
      m_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (en) begin
      v_q[0] <= !q_stat_i.empty;
      for (int k = 1; k <= S; k++) v_q[k] <= v_q[k-1];
      m_v_q <= v_q[S];
      o_v_q <= m_v_q;
    end
  end

  assign out_ch.valid    = o_v_q;
  assign out_ch.hit_kind = o_kind_q;
  assign out_ch.hit_x    = o_x_q;
  assign out_ch.hit_y    = o_y_q;

endmodule

// ----- src/ray_segment_intersect.sv -----
// ----------------------------------------------------------------------------
// ray_segment_intersect
// Pipeline: CORDIC stages in the front, bit-per-stage divider in the back.
// Throughput: one item per cycle unless out_ch.ready holds the output back;
// a 4-entry queue decouples front and back.
// Reset: asynchronous, active low; clears valid state, near_zero_limit to 1.
// ----------------------------------------------------------------------------
module ray_segment_intersect
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsi_in_if.sink      in_ch,
  rsi_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NW = cross_w(FRAC_BITS);

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [32:0] sx;
    logic signed [32:0] sy;
    logic [NW-1:0]      n;
    logic [NW-1:0]      d;
  } entry_t;

  logic [15:0] near_zero_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NEAR_ZERO) ? {16'h0000, near_zero_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_zero_q <= 16'd1;
    end else if (psel && penable && pwrite && paddr[2] == REG_NEAR_ZERO) begin
      near_zero_q <= pwdata[15:0];
    end
  end

  q_stat_t q_stat;
  logic    push, pop;
  entry_t  push_data, pop_data;

  rsi_front #(
    .FRAC_BITS   (FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS),
    .entry_t     (entry_t)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .near_zero_i(near_zero_q),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .entry_o    (push_data)
  );

  rsi_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .entry_t(entry_t)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i(push_data),
    .pop_i (pop),
    .data_o(pop_data),
    .stat_o(q_stat)
  );

  rsi_back #(
    .FRAC_BITS(FRAC_BITS),
    .entry_t  (entry_t)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_stat_i(q_stat),
    .entry_i (pop_data),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- src/rsi_checker.sv -----
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks of the ray/segment intersection block.
// ----------------------------------------------------------------------------
`include "ray_segment_intersect_assert.svh"

module rsi_checker
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  hit_kind,
  input logic [31:0] hit_x,
  input logic [31:0] hit_y,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  localparam logic [31:0] MISS = ~((32'd1 << FRAC_BITS) - 32'd1);

  `RSI_ASSERT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid && $stable(hit_kind) && $stable(hit_x) && $stable(hit_y))
  `RSI_ASSERT(a_miss_value, clk_i, rst_ni, out_valid && hit_kind == KIND_NONE |-> hit_x == MISS && hit_y == MISS)
  `RSI_ASSERT(a_cfg_readback, clk_i, rst_ni, psel && penable && pwrite && paddr[2] == REG_NEAR_ZERO |=> paddr[2] != REG_NEAR_ZERO || prdata[15:0] == $past(pwdata[15:0]))
  // valid is cleared asynchronously while reset is low
  `RSI_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid)

endmodule

bind ray_segment_intersect rsi_checker #(.FRAC_BITS(FRAC_BITS)) u_rsi_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .hit_kind (out_ch.hit_kind),
  .hit_x    (out_ch.hit_x),
  .hit_y    (out_ch.hit_y),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ray_segment_intersect: a directed table of
// extremes, crossings, colinear and miss cases, then random segments and
// rays under several near-zero limits. Every result is checked against an
// in-bench fixed-point predictor, or a fixed miss for the typed directed rows,
// while the sender bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import rsi_pkg::*;

  localparam int  FB        = 16;
  localparam int  STEPS     = 16;
  localparam int  LATENCY   = 43;
  localparam int  CYCLE_MAX = 600000;
  localparam int  PER_PHASE = 288;
  localparam logic [2:0] ADDR_NEAR_ZERO = {REG_NEAR_ZERO, 2'b00};
  localparam logic signed [31:0] MISS_VAL = -(32'sd1 <<< FB);

  typedef struct {
    logic signed [31:0] qx, qy, ex, ey, px, py;
    logic        [15:0] ang;
  } probe_t;

  typedef struct {
    kind_e              kind;
    logic signed [31:0] x, y;
  } hit_t;

  typedef struct {
    probe_t pr;
    bit     typed;
    hit_t   hit;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rsi_in_if  in_ch ();
  rsi_out_if out_ch ();

  ray_segment_intersect dut (
    .clk_i(clk), .rst_ni(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [15:0] tol_reg = 16'd1;
  hit_t        hits_due[$];
  row_t        dir_tab[$];
  int          errors = 0;
  int          sent = 0, seen = 0, crossings = 0, colinears = 0;
  int          cycles = 0;
  int          burst_left = 0;

  // ---------------------------------------------------------------- predictor
  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic cast_dir(input logic [15:0] ang, output longint rx, output longint ry);
    logic [31:0] a;
    bit          flip;
    longint      x, y, z, dx, dy;
    a = {ang, 16'h0000};
    flip = (a >= 32'h40000000) && (a < 32'hC0000000);
    if (flip) a ^= 32'h80000000;
    z = longint'($signed(a));
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TABLE[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TABLE[i]);
      end
    end
    x = (x + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
    y = (y + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
    if (flip) begin
      x = -x; y = -y;
    end
    rx = x;
    ry = y;
  endtask

  task automatic predict_hit(input probe_t p, input logic [15:0] lim, output hit_t h);
    longint qx, qy, ex, ey, px, py, sx, sy, wx, wy, rx, ry, rxs, wxr, tol;
    longint d1, d2, dd, n, dn;
    longint unsigned un, ud, uf;
    logic signed [71:0] c1, c2;
    int ts;
    qx = p.qx; qy = p.qy; ex = p.ex; ey = p.ey; px = p.px; py = p.py;
    sx = ex - qx; sy = ey - qy; wx = qx - px; wy = qy - py;
    cast_dir(p.ang, rx, ry);
    rxs = rx * sy - ry * sx;
    wxr = wx * ry - wy * rx;
    tol = longint'(lim) <<< FB;
    h.kind = KIND_NONE; h.x = MISS_VAL; h.y = MISS_VAL;
    if (mag(rxs) <= tol) begin
      if (mag(wxr) <= tol) begin
        d1 = (wx * rx + wy * ry) >>> FB;
        d2 = ((ex - px) * rx + (ey - py) * ry) >>> FB;
        if (d1 < 0 && d2 < 0) return;
        if (d1 < 0) dd = d2;
        else if (d2 < 0) dd = d1;
        else dd = d1 < d2 ? d1 : d2;
        h.kind = KIND_COLIN;
        h.x = clip32(px + ((rx * dd) >>> FB));
        h.y = clip32(py + ((ry * dd) >>> FB));
      end
      return;
    end
    c1 = 72'(wx) * 72'(sy);
    c2 = 72'(wy) * 72'(sx);
    ts = (c1 > c2) ? 1 : (c1 < c2) ? -1 : 0;
    if (ts != 0 && ((ts < 0) != (rxs < 0))) return;
    n = wxr; dn = rxs;
    if (dn < 0) begin
      n = -n; dn = -dn;
    end
    if (n < 0 || n > dn) return;
    un = n; ud = dn; uf = 0;
    if (un >= ud) begin
      uf = 1; un -= ud;
    end
    for (int i = 0; i < FB; i++) begin
      un <<= 1; uf <<= 1;
      if (un >= ud) begin
        un -= ud; uf |= 1;
      end
    end
    h.kind = KIND_CROSS;
    h.x = clip32(qx + ((sx * longint'(uf)) >>> FB));
    h.y = clip32(qy + ((sy * longint'(uf)) >>> FB));
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [31:0] fx(input int v);
    return v <<< FB;
  endfunction

  function automatic logic signed [31:0] near_val();
    return $signed($urandom_range(0, 32'h007FFFFF)) - 32'sh00400000;
  endfunction

  function automatic probe_t rand_probe();
    probe_t p;
    int     mode;
    mode = $urandom_range(0, 99);
    p.qx = near_val(); p.qy = near_val(); p.ex = near_val(); p.ey = near_val();
    p.px = near_val(); p.py = near_val(); p.ang = $urandom_range(0, 65535);
    if (mode < 15) begin
      p.qx = $urandom; p.qy = $urandom; p.ex = $urandom; p.ey = $urandom;
      p.px = $urandom; p.py = $urandom;
    end else if (mode < 38) begin
      // put the segment end on the axis line through the ray origin, its start within one LSB of it
      p.ang = 16'(16384 * $urandom_range(0, 3));
      if (p.ang[14]) begin
        p.qx = p.px + $signed($urandom_range(0, 2)) - 1; p.ex = p.px;
      end else begin
        p.qy = p.py + $signed($urandom_range(0, 2)) - 1; p.ey = p.py;
      end
    end
    return p;
  endfunction

  function automatic probe_t mk(input int qx, qy, ex, ey, px, py, input int ang);
    probe_t p;
    p.qx = fx(qx); p.qy = fx(qy); p.ex = fx(ex); p.ey = fx(ey);
    p.px = fx(px); p.py = fx(py); p.ang = ang[15:0];
    return p;
  endfunction

  task automatic add_row(input probe_t p, input bit typed, input kind_e k);
    row_t r;
    r.pr = p; r.typed = typed;
    r.hit.kind = k; r.hit.x = MISS_VAL; r.hit.y = MISS_VAL;
    dir_tab.push_back(r);
  endtask

  task automatic send_probe(input probe_t p, input bit typed, input hit_t typed_hit);
    hit_t h;
    in_ch.valid <= 1'b1;
    in_ch.seg_start_x <= p.qx; in_ch.seg_start_y <= p.qy;
    in_ch.seg_end_x <= p.ex;   in_ch.seg_end_y <= p.ey;
    in_ch.ray_start_x <= p.px; in_ch.ray_start_y <= p.py;
    in_ch.ray_angle <= p.ang;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (typed) h = typed_hit;
    else predict_hit(p, tol_reg, h);
    hits_due.push_back(h);
    sent++;
    if (burst_left > 0) burst_left--;
    else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic write_tol(input logic [15:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_NEAR_ZERO; pwdata <= {16'h0000, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    tol_reg = v;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (hits_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- receiver
  int stall_mode = 0;
  always @(posedge clk) begin
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 9) < 7);
      2: out_ch.ready <= (cycles % 7) < 4;
      default: out_ch.ready <= ($urandom_range(0, 9) < 2);
    endcase
  end

  always @(posedge clk) begin
    hit_t h;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen++;
      if (hits_due.size() == 0) begin
        $display("%0t: unexpected item kind=%0d x=%h y=%h", $time,
                 out_ch.hit_kind, out_ch.hit_x, out_ch.hit_y);
        errors++;
      end else begin
        h = hits_due.pop_front();
        if (h.kind == KIND_CROSS) crossings++;
        if (h.kind == KIND_COLIN) colinears++;
        if (out_ch.hit_kind !== h.kind) begin
          $display("%0t: hit_kind expected %0d actual %0d", $time, h.kind, out_ch.hit_kind);
          errors++;
        end
        if (out_ch.hit_x !== h.x) begin
          $display("%0t: hit_x expected %h actual %h", $time, h.x, out_ch.hit_x);
          errors++;
        end
        if (out_ch.hit_y !== h.y) begin
          $display("%0t: hit_y expected %h actual %h", $time, h.y, out_ch.hit_y);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("timeout after %0d cycles, %0d items pending", cycles, hits_due.size());
      $display("[ray_segment_intersect] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main
  initial begin
    logic [15:0] tols [4];
    hit_t        dummy;
    in_ch.valid = 1'b0;
    in_ch.seg_start_x = '0; in_ch.seg_start_y = '0; in_ch.seg_end_x = '0;
    in_ch.seg_end_y = '0; in_ch.ray_start_x = '0; in_ch.ray_start_y = '0;
    in_ch.ray_angle = '0;
    dummy.kind = KIND_NONE; dummy.x = MISS_VAL; dummy.y = MISS_VAL;

    add_row(mk(0, 0, 0, 0, 0, 0, 0), 0, KIND_NONE);
    add_row('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'hFFFF}, 0, KIND_NONE);
    add_row('{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 32'sh80000000, 16'h8000}, 0, KIND_NONE);
    add_row('{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              32'sh00000000, 32'sh00000000, 16'h4000}, 0, KIND_NONE);
    add_row('{32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
              32'sh7FFFFFFF, 32'sh80000000, 16'h2000}, 0, KIND_NONE);
    // segment behind the ray origin
    add_row(mk(-10, -5, -10, 5, 0, 0, 0), 1, KIND_NONE);
    // crossing outside the segment, before its start
    add_row(mk(10, 5, 10, 10, 0, 0, 0), 1, KIND_NONE);
    add_row(mk(10, -5, 10, 5, 0, 0, 0), 0, KIND_NONE);
    add_row(mk(-5, 10, 5, 10, 0, 0, 16384), 0, KIND_NONE);
    add_row(mk(-10, -5, -10, 5, 0, 0, 32768), 0, KIND_NONE);
    add_row(mk(-5, -10, 5, -10, 0, 0, 49152), 0, KIND_NONE);
    add_row(mk(10, 0, 10, 10, 0, 0, 0), 0, KIND_NONE);
    add_row(mk(5, 0, 20, 0, 0, 0, 0), 0, KIND_NONE);
    add_row(mk(20, 0, 5, 0, 0, 0, 0), 0, KIND_NONE);
    add_row(mk(-5, 0, 20, 0, 0, 0, 0), 0, KIND_NONE);
    add_row(mk(-20, 0, -5, 0, 0, 0, 0), 0, KIND_NONE);
    add_row(mk(0, 5, 20, 5, 0, 0, 0), 0, KIND_NONE);
    add_row(mk(3, 4, 3, 40, 3, 1, 16384), 0, KIND_NONE);
    add_row(mk(7, 7, 7, 7, 0, 0, 8192), 0, KIND_NONE);
    add_row(mk(32767, -100, -32768, 100, 0, 0, 16384), 0, KIND_NONE);
    add_row(mk(32000, -5, 32000, 5, -32000, 0, 0), 0, KIND_NONE);
    add_row(mk(-3, 2, 4, -2, 0, 0, 12345), 0, KIND_NONE);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of the limit first
    foreach (dir_tab[i]) send_probe(dir_tab[i].pr, dir_tab[i].typed, dir_tab[i].hit);
    drain();

    tols[0] = 16'd0;
    tols[1] = 16'hFFFF;
    tols[2] = $urandom_range(2, 4000);
    tols[3] = 16'd1;
    for (int ph = 0; ph < 4; ph++) begin
      write_tol(tols[ph]);
      burst_left = 0;
      for (int k = 0; k < PER_PHASE; k++) begin
        if (ph == 1 && k == 100) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (hits_due.size() != 0) @(posedge clk);
        end
        send_probe(rand_probe(), 0, dummy);
      end
      drain();
    end

    $display("sent %0d items, checked %0d results (%0d crossings, %0d colinear)",
             sent, seen, crossings, colinears);
    $display("limits covered: reset, 0, 65535, %0d, 1", tols[2]);
    if (errors == 0 && hits_due.size() == 0) begin
      $display("[ray_segment_intersect] OK");
    end else begin
      $display("[ray_segment_intersect] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/rsi_pkg.sv
src/rsi_in_if.sv
src/rsi_out_if.sv
src/rsi_cordic.sv
src/rsi_front.sv
src/rsi_queue.sv
src/rsi_back.sv
src/ray_segment_intersect.sv
src/rsi_checker.sv
tb/tb_top.sv
